### hw/rtl/cbf_pkg.sv
// types, constants and register indexes shared by the chunk stream framer
`timescale 1ns / 1ps

package cbf_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_CHANNEL          = 3'd0;
    localparam logic [2:0] CFG_CHUNK_SIZE       = 3'd1;
    localparam logic [2:0] CFG_FIRST_HEADER_LEN = 3'd2;
    localparam logic [2:0] CFG_EXT_TS_ENABLE    = 3'd3;
    localparam logic [2:0] CFG_EXT_TS_VALUE     = 3'd4;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // basic header format and channel ranges
    localparam logic [7:0]  HDR_MINIMAL       = 8'hC0;
    localparam logic [16:0] CHAN_MIN          = 17'd2;
    localparam logic [16:0] CHAN_ONE_BYTE_MAX = 17'd63;
    localparam logic [16:0] CHAN_TWO_BYTE_MAX = 17'd319;
    localparam logic [16:0] CHAN_OFFSET       = 17'd64;
    localparam logic [16:0] CHAN_MAX          = 17'd65599;
    localparam logic [4:0]  FHL_MIN           = 5'd1;
    localparam logic [4:0]  FHL_MAX           = 5'd18;
    localparam logic [24:0] COUNT_MAX         = 25'h1FF_FFFF;

    // one run holds up to three basic header bytes, four timestamp bytes and the data byte
    localparam int unsigned RUN_MAX = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic [16:0] channel;
        logic [23:0] chunk_size;
        logic [4:0]  first_header_len;
        logic        ext_ts_enable;
        logic [31:0] ext_ts_value;
    } cfg_t;

    // bytes of one run, the data byte at position last_idx
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [2:0]              last_idx;
    } run_t;

endpackage

### hw/rtl/cbf_header_gen.sv
// builds the run of header bytes and the data byte for one incoming beat
`timescale 1ns / 1ps

module cbf_header_gen (
    input  cbf_pkg::cfg_t     cfg,
    input  logic [24:0]       bytes_in_chunk,
    input  cbf_pkg::in_beat_t in_beat,
    output logic              insert_hdr,
    output cbf_pkg::run_t     run
);

    logic        active;
    logic [16:0] id;
    logic [2:0]  nb;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [2:0]  pos;

    // chunking is on only for a legal channel, size and first header length
    assign active = (cfg.channel >= cbf_pkg::CHAN_MIN) && (cfg.channel <= cbf_pkg::CHAN_MAX) &&
                    (cfg.chunk_size != 24'd0) &&
                    (cfg.first_header_len >= cbf_pkg::FHL_MIN) &&
                    (cfg.first_header_len <= cbf_pkg::FHL_MAX);

    assign insert_hdr = active && (bytes_in_chunk >= {1'b0, cfg.chunk_size});

    assign id = cfg.channel - cbf_pkg::CHAN_OFFSET;

    // basic header: one, two or three bytes by channel range
    always_comb begin
        b1 = id[7:0];
        b2 = id[15:8];
        if (cfg.channel <= cbf_pkg::CHAN_ONE_BYTE_MAX) begin
            nb = 3'd1;
            b0 = cbf_pkg::HDR_MINIMAL | cfg.channel[7:0];
        end else if (cfg.channel <= cbf_pkg::CHAN_TWO_BYTE_MAX) begin
            nb = 3'd2;
            b0 = cbf_pkg::HDR_MINIMAL;
        end else begin
            nb = 3'd3;
            b0 = cbf_pkg::HDR_MINIMAL | 8'h01;
        end
    end

    // lay out header, optional timestamp and data byte
    always_comb begin
        run = '0;
        pos = 3'd0;
        if (insert_hdr) begin
            run.bytes[0] = b0;
            run.bytes[1] = b1;
            run.bytes[2] = b2;
            pos = nb;
            if (cfg.ext_ts_enable) begin
                run.bytes[pos]        = cfg.ext_ts_value[31:24];
                run.bytes[pos + 3'd1] = cfg.ext_ts_value[23:16];
                run.bytes[pos + 3'd2] = cfg.ext_ts_value[15:8];
                run.bytes[pos + 3'd3] = cfg.ext_ts_value[7:0];
                pos = pos + 3'd4;
            end
        end
        run.bytes[pos] = in_beat.data_byte;
        run.last_idx   = pos;
    end

endmodule

### hw/rtl/cbf_run_buffer.sv
// output register holding one run and handing it out a beat per cycle while m_ready is high
`timescale 1ns / 1ps

module cbf_run_buffer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  cbf_pkg::run_t      run_in,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output cbf_pkg::out_beat_t m_data
);

    logic          valid_reg;
    logic          valid_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    cbf_pkg::run_t run_reg;
    logic          at_last;

    assign at_last  = (idx_reg == run_reg.last_idx);
    // a new run may enter as the last beat of the current one leaves
    assign can_load = !valid_reg || (m_ready && at_last);

    // beat sequencing
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end else if (valid_reg && m_ready) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // run payload
    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run_in;
        end
    end

    assign m_valid            = valid_reg;
    assign m_data.out_byte    = run_reg.bytes[idx_reg];
    assign m_data.is_header   = !at_last;
    assign m_data.last_of_run = at_last;

endmodule

### hw/rtl/chunk_stream_framer.sv
// top level of the chunk stream framer: config registers, chunk counter, output run buffer
`timescale 1ns / 1ps

// channel  | dir | handshake         | payload
// s_       | in  | s_valid / s_ready | cbf_pkg::in_beat_t  (data_byte, msg_end)
// m_       | out | m_valid / m_ready | cbf_pkg::out_beat_t (out_byte, is_header, last_of_run)
// cfg_     | in  | cfg_wr_en         | cfg_addr, cfg_wdata
//
// a byte with no inserted header leaves as a single beat; a byte at a chunk boundary
// leaves as 1..3 basic header beats, 4 timestamp beats when enabled, then the data beat (up to 8 beats)
// the output run register hands out one beat per cycle while m_ready is high
// s_ready stays high while the last beat of the current run leaves, so runs go back to back
// reset is synchronous on aresetn low; it clears the counter and the run buffer
// m_ready low holds the current beat and stalls intake once its run is done

module chunk_stream_framer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cbf_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cbf_pkg::out_beat_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [cbf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cbf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    cbf_pkg::cfg_t cfg_reg;
    cbf_pkg::cfg_t cfg_next;
    logic [24:0]   cnt_reg;
    logic [24:0]   cnt_next;
    logic          in_first_reg;
    logic          in_first_next;
    logic          insert_hdr;
    cbf_pkg::run_t run;
    logic          accept;

    // configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                cbf_pkg::CFG_CHANNEL:          cfg_next.channel          = cfg_wdata[16:0];
                cbf_pkg::CFG_CHUNK_SIZE:       cfg_next.chunk_size       = cfg_wdata[23:0];
                cbf_pkg::CFG_FIRST_HEADER_LEN: cfg_next.first_header_len = cfg_wdata[4:0];
                cbf_pkg::CFG_EXT_TS_ENABLE:    cfg_next.ext_ts_enable    = cfg_wdata[0];
                cbf_pkg::CFG_EXT_TS_VALUE:     cfg_next.ext_ts_value     = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel          <= 17'd0;
            cfg_reg.chunk_size       <= 24'd128;
            cfg_reg.first_header_len <= 5'd0;
            cfg_reg.ext_ts_enable    <= 1'b0;
            cfg_reg.ext_ts_value     <= 32'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // header decision and run layout
    cbf_header_gen u_header_gen (
        .cfg            (cfg_reg),
        .bytes_in_chunk (cnt_reg),
        .in_beat        (s_data),
        .insert_hdr     (insert_hdr),
        .run            (run)
    );

    // output run register
    cbf_run_buffer u_run_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .run_in   (run),
        .can_load (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign accept = s_valid && s_ready;

    // chunk position counter, saturating, cleared at message end
    always_comb begin
        cnt_next      = cnt_reg;
        in_first_next = in_first_reg;
        if (accept) begin
            if (insert_hdr) begin
                cnt_next      = 25'd1;
                in_first_next = 1'b0;
            end else if (cnt_reg != cbf_pkg::COUNT_MAX) begin
                cnt_next = cnt_reg + 25'd1;
            end
            if (s_data.msg_end) begin
                cnt_next      = 25'd0;
                in_first_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= 25'd0;
            in_first_reg <= 1'b1;
        end else begin
            cnt_reg      <= cnt_next;
            in_first_reg <= in_first_next;
        end
    end

    // message end puts the counter back at the start of a first chunk
    a_msg_end_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.msg_end |=> (cnt_reg == 25'd0) && in_first_reg)
        else $error("counter not rewound after message end");

    // an inserted header starts a continuation chunk holding the data byte
    a_hdr_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && insert_hdr && !s_data.msg_end |=> (cnt_reg == 25'd1) && !in_first_reg)
        else $error("counter not restarted after header");

    // a run with a header leaves the data byte behind it, so intake must wait
    a_hdr_holds_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && insert_hdr |=> m_valid && m_data.is_header && !s_ready)
        else $error("header run did not hold intake");

endmodule
